/* sv/press_length_lamp_dimmer_assert.svh */
// Assertion macros for the press-length lamp dimmer.
// Used inside modules that declare aclk and aresetn.
`ifndef PRESS_LENGTH_LAMP_DIMMER_ASSERT_SVH
`define PRESS_LENGTH_LAMP_DIMMER_ASSERT_SVH

// consequent checked in the same cycle
`define PLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the following cycle
`define PLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pld_pkg.sv */
// Package for the press-length lamp dimmer: register map, reset values
// and the colour scaling function. No dependencies.
package pld_pkg;

    localparam int unsigned CfgAddrW = 5;

    localparam logic [7:0]  LONG_PRESS_RST  = 8'd10;
    localparam logic [7:0]  DIM_INTERVAL_RST = 8'd10;
    localparam logic [7:0]  ON_BRIGHT_RST   = 8'd200;
    localparam logic [23:0] SHORT_COLOR_RST = 24'hFF0000;
    localparam logic [23:0] LONG_COLOR_RST  = 24'hFFFFFF;

    typedef enum logic [2:0] {
        REG_LONG_PRESS   = 3'd0,
        REG_DIM_INTERVAL = 3'd1,
        REG_ON_BRIGHT    = 3'd2,
        REG_SHORT_COLOR  = 3'd3,
        REG_LONG_COLOR   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] third;
        logic [7:0] second;
        logic [7:0] first;
    } frame_t;

    // c * b / 255, truncated, exact for every product of two bytes
    function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = {8'd0, c} * {8'd0, b};
        sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

/* sv/press_length_lamp_dimmer.sv */
// Press-length lamp dimmer: button tick stream in, LED frame stream out.
// Input channel s_axis_*: one transaction per tick, tdata[0] = first sample
//   low, tdata[1] = confirm sample low; the button is held when both are set.
// Output channel m_axis_*: one transaction per lamp update (release of the
//   button, or one dimming step while idle). tdata holds the scaled green,
//   red and blue bytes and the brightness used; every LED shows this frame.
// Configuration: APB port, registers at byte addresses 0,4,8,12,16 (long
//   press ticks, dim interval, on brightness, short and long press colour).
// Path: a tick is registered on acceptance and its result is written to the
//   output register once the output is free, which raises tvalid.
// Throughput: one tick per cycle unless stalled; the state update and the 8x8
//   scaling multipliers form the single stage between input and output register.
// Stall: while m_axis_tready is low and a frame waits, a held tick stays in
//   the input register and s_axis_tready drops; ticks that give no frame
//   pass through without waiting on the receiver once the output is free.
// Reset: aresetn (synchronous, active low) clears both registers' valid
//   flags, the counters, brightness and colour (lamp black), and loads the
//   configuration defaults.
`include "press_length_lamp_dimmer_assert.svh"

module press_length_lamp_dimmer
    import pld_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // [0] pin_low_first, [1] pin_low_confirm

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,  // [7:0] wire_first_byte,
                                               // [15:8] wire_second_byte,
                                               // [23:16] wire_third_byte,
                                               // [31:24] level_now

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]  long_press_reg;
    logic [7:0]  dim_interval_reg;
    logic [7:0]  on_bright_reg;
    logic [23:0] short_color_reg;
    logic [23:0] long_color_reg;

    logic        in_valid_reg;
    logic [1:0]  pins_reg;

    logic [7:0]  press_ticks_reg, press_ticks_next;
    logic [7:0]  idle_ticks_reg,  idle_ticks_next;
    logic [7:0]  level_reg,       level_next;
    logic [23:0] color_reg,       color_next;

    logic        out_valid_reg;
    frame_t      frame_reg, frame_next;

    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    logic        advance;
    logic        proc;
    logic        pressed;
    logic        emit;
    logic [7:0]  idle_inc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[CfgAddrW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg   <= LONG_PRESS_RST;
            dim_interval_reg <= DIM_INTERVAL_RST;
            on_bright_reg    <= ON_BRIGHT_RST;
            short_color_reg  <= SHORT_COLOR_RST;
            long_color_reg   <= LONG_COLOR_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LONG_PRESS:   long_press_reg   <= pwdata[7:0];
                REG_DIM_INTERVAL: dim_interval_reg <= pwdata[7:0];
                REG_ON_BRIGHT:    on_bright_reg    <= pwdata[7:0];
                REG_SHORT_COLOR:  short_color_reg  <= pwdata[23:0];
                REG_LONG_COLOR:   long_color_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LONG_PRESS:   prdata = {24'd0, long_press_reg};
            REG_DIM_INTERVAL: prdata = {24'd0, dim_interval_reg};
            REG_ON_BRIGHT:    prdata = {24'd0, on_bright_reg};
            REG_SHORT_COLOR:  prdata = {8'd0, short_color_reg};
            REG_LONG_COLOR:   prdata = {8'd0, long_color_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            pins_reg <= s_axis_tdata[1:0];
        end
    end

    assign pressed  = pins_reg[0] && pins_reg[1];
    assign idle_inc = (idle_ticks_reg <= dim_interval_reg && idle_ticks_reg != 8'hFF)
                      ? idle_ticks_reg + 8'd1 : idle_ticks_reg;

    always_comb begin
        press_ticks_next = press_ticks_reg;
        idle_ticks_next  = idle_ticks_reg;
        level_next       = level_reg;
        color_next       = color_reg;
        emit             = 1'b0;
        if (pressed) begin
            if (press_ticks_reg != 8'hFF) begin
                press_ticks_next = press_ticks_reg + 8'd1;
            end
        end else if (press_ticks_reg == 8'd0) begin
            idle_ticks_next = idle_inc;
            if (level_reg != 8'd0 && idle_inc > dim_interval_reg) begin
                level_next      = level_reg - 8'd1;
                idle_ticks_next = 8'd0;
                emit            = 1'b1;
            end
        end else begin
            if (press_ticks_reg < long_press_reg) begin
                if (level_reg == 8'd0) begin
                    level_next = on_bright_reg;
                    color_next = short_color_reg;
                end else begin
                    level_next = 8'd0;
                end
            end else begin
                level_next = on_bright_reg;
                color_next = long_color_reg;
            end
            press_ticks_next = 8'd0;
            emit             = 1'b1;
        end
    end

    always_comb begin
        frame_next.first  = scale_byte(color_next[15:8],  level_next);
        frame_next.second = scale_byte(color_next[23:16], level_next);
        frame_next.third  = scale_byte(color_next[7:0],   level_next);
        frame_next.level  = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_ticks_reg <= 8'd0;
            idle_ticks_reg  <= 8'd0;
            level_reg       <= 8'd0;
            color_reg       <= 24'd0;
        end else if (proc) begin
            press_ticks_reg <= press_ticks_next;
            idle_ticks_reg  <= idle_ticks_next;
            level_reg       <= level_next;
            color_reg       <= color_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            frame_reg <= frame_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = frame_reg;

    `PLD_ASSERT_NOW(a_stall_holds_tick, !s_axis_tready, in_valid_reg,
        "input stalled with no tick held")
    `PLD_ASSERT_NOW(a_dark_frame, m_axis_tvalid && m_axis_tdata[31:24] == 8'd0,
        m_axis_tdata[23:0] == 24'd0, "frame at zero brightness is not black")
    `PLD_ASSERT_NEXT(a_level_only_on_tick, !proc, $stable(level_reg),
        "brightness changed without a tick")
    `PLD_ASSERT_NEXT(a_held_no_frame, proc && pressed, !m_axis_tvalid,
        "frame produced while the button is held")

endmodule
